FILE: rtl/indexed_stack_with_delete_assert.svh
// assertion helpers for the stack rtl
`ifndef INDEXED_STACK_WITH_DELETE_ASSERT_SVH
`define INDEXED_STACK_WITH_DELETE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ISD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isd check failed");

// next-cycle implication, checked out of reset
`define ISD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isd check failed");

`endif

FILE: rtl/isd_pkg.sv
package isd_pkg;

  // storage geometry
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned OCC_W      = $clog2(DEPTH + 1);

  // request kinds
  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_POP    = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_DELETE = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // request transaction
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] item_value;
    logic [5:0]  position;
  } isd_in_t;

  // result transaction
  typedef struct packed {
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [6:0]  fill_count;
  } isd_out_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } isd_mem_req_t;

endpackage

FILE: rtl/isd_mem.sv
module isd_mem (
  input  logic                                clk_i,
  input  isd_pkg::isd_mem_req_t               req_i,
  output logic [isd_pkg::DATA_WIDTH-1:0]      rdata_o
);
  import isd_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/isd_ctrl.sv
`include "indexed_stack_with_delete_assert.svh"

module isd_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  isd_pkg::isd_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output isd_pkg::isd_out_t                out_data_o,
  output isd_pkg::isd_mem_req_t            mem_req_o,
  input  logic [isd_pkg::DATA_WIDTH-1:0]   mem_rdata_i
);
  import isd_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_RD_WAIT  = 3'd2;
  localparam logic [2:0] S_DEL_WAIT = 3'd3;
  localparam logic [2:0] S_SH_RD    = 3'd4;
  localparam logic [2:0] S_SH_WAIT  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [OCC_W-1:0]      occ_q, occ_d;
  logic [2:0]            kind_q, kind_d;
  logic [ADDR_W-1:0]     pos_q, pos_d;
  logic [ADDR_W-1:0]     idx_q, idx_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  out_valid_q, out_valid_d;
  isd_out_t              out_data_q, out_data_d;

  logic                  fin;
  logic [1:0]            fin_status;
  logic [DATA_WIDTH-1:0] fin_value;
  logic [OCC_W-1:0]      pos_ext;
  logic [OCC_W-1:0]      idx_nxt;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign pos_ext     = OCC_W'(pos_q);
  assign idx_nxt     = OCC_W'(idx_q) + OCC_W'(1);

  // sequencer: one transaction at a time; a delete shift reads the entry above the gap, then writes it
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    mem_req_o   = '0;
    fin         = 1'b0;
    fin_status  = STATUS_OK;
    fin_value   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          kind_d  = in_data_i.kind;
          val_d   = DATA_WIDTH'(in_data_i.item_value);
          pos_d   = ADDR_W'(in_data_i.position);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (kind_q)
          KIND_PUSH: begin
            fin = 1'b1;
            if (occ_q == OCC_W'(DEPTH)) begin
              fin_status = STATUS_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = occ_q[ADDR_W-1:0];
              mem_req_o.wdata = val_q;
              occ_d           = occ_q + OCC_W'(1);
            end
          end
          KIND_POP: begin
            if (occ_q == '0) begin
              fin        = 1'b1;
              fin_status = STATUS_RANGE;
            end else begin
              occ_d           = occ_q - OCC_W'(1);
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = ADDR_W'(occ_q - OCC_W'(1));
              state_d         = S_RD_WAIT;
            end
          end
          KIND_CLEAR: begin
            fin   = 1'b1;
            occ_d = '0;
          end
          KIND_READ: begin
            if (pos_ext >= occ_q) begin
              fin        = 1'b1;
              fin_status = STATUS_RANGE;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = pos_q;
              state_d         = S_RD_WAIT;
            end
          end
          KIND_DELETE: begin
            if (pos_ext >= occ_q) begin
              fin        = 1'b1;
              fin_status = STATUS_RANGE;
            end else begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = pos_q;
              idx_d           = pos_q;
              state_d         = S_DEL_WAIT;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_RD_WAIT: begin
        fin       = 1'b1;
        fin_value = mem_rdata_i;
      end
      S_DEL_WAIT: begin
        val_d   = mem_rdata_i;
        state_d = S_SH_RD;
      end
      // fetch the entry above the gap, or close out the delete
      S_SH_RD: begin
        if (idx_nxt < occ_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_nxt[ADDR_W-1:0];
          state_d         = S_SH_WAIT;
        end else begin
          occ_d     = occ_q - OCC_W'(1);
          fin       = 1'b1;
          fin_value = val_q;
        end
      end
      S_SH_WAIT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_nxt[ADDR_W-1:0];
        state_d         = S_SH_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // load the result register
    if (fin) begin
      state_d               = S_IDLE;
      out_valid_d           = 1'b1;
      out_data_d.value_out  = 32'(fin_value);
      out_data_d.status     = fin_status;
      out_data_d.fill_count = 7'(occ_d);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

  `ISD_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OCC_W'(DEPTH))
  `ISD_ASSERT_NOW(a_ready_no_pending, in_ready_o, !out_valid_q && (state_q == S_IDLE))
  `ISD_ASSERT_NOW(a_full_means_full,
                  out_valid_q && (out_data_q.status == STATUS_FULL),
                  out_data_q.fill_count == 7'(DEPTH))
  `ISD_ASSERT_NOW(a_err_zero_value,
                  out_valid_q && (out_data_q.status != STATUS_OK),
                  out_data_q.value_out == '0)
  `ISD_ASSERT_NEXT(a_accept_to_exec, in_valid_i && in_ready_o, state_q == S_EXEC)

endmodule

FILE: rtl/indexed_stack_with_delete.sv
// each accepted request enters S_EXEC; push, clear and out-of-range requests finish there,
// pop and read finish in S_RD_WAIT, and delete passes S_DEL_WAIT before its shift
// the delete shift moves each entry above the gap down through the single memory port
// throughput: one transaction at a time; a new one is taken the cycle after the result drains
// reset clears the fill count and the handshake state; stored words are not cleared
module indexed_stack_with_delete (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  isd_pkg::isd_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output isd_pkg::isd_out_t  out_data_o
);
  import isd_pkg::*;

  isd_mem_req_t          mem_req;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // sequencer
  isd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // entry storage
  isd_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
